// File: sv/tss_pkg.sv
// Shared types and fixed constants of the stereo transient shaper.
`timescale 1ns / 1ps

package tss_pkg;

  // Control sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_DONE
  } fsm_t;

  // Sequencer steps, one per cycle per channel; all but SP_T_WB and SP_OUT_WB use the MAC unit.
  typedef enum logic [3:0] {
    SP_FAST_MUL,
    SP_FAST_MAC,
    SP_SLOW_MUL,
    SP_SLOW_MAC,
    SP_ATT_SENSE,
    SP_ATT_GAIN,
    SP_SUS_SENSE,
    SP_SUS_GAIN,
    SP_DRY_GAIN,
    SP_T_WB,
    SP_WET_MUL,
    SP_DRY_MIX,
    SP_WET_MIX,
    SP_OUT_WB
  } step_t;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX     = 8'd3;

  // Register field widths and Q12 limits.
  localparam int AMT_W   = 14;
  localparam int CTL_W   = 13;
  localparam int SENSE_W = 15;
  localparam logic signed [AMT_W-1:0] AMT_MAX = 14'sd4096;
  localparam logic signed [AMT_W-1:0] AMT_MIN = -14'sd4096;
  localparam logic [CTL_W-1:0]        Q12_ONE = 13'd4096;
  localparam logic [SENSE_W-1:0]      SENSE_OFS = 15'd2048;
  localparam logic [CTL_W-1:0]        SENSE_RST = 13'd2048;

  // Gains are Q24 and held in a 28-bit signed word.
  localparam int GAIN_BITS = 24;
  localparam int GAIN_W    = 28;
  localparam int GAIN_ONE   = 16777216;
  localparam int GAIN_FLOOR = 1677722;

  // Mix fraction bits and width of the rounding shift amount.
  localparam int MIX_FRAC = 12;
  localparam int RND_SH_W = 6;

endpackage

// File: sv/transient_shaper_stereo_top.sv
// Stereo transient shaper built around one shared multiply-accumulate unit.
// Each stereo pair runs through 14 sequencer steps per channel, 12 of them on the multiplier,
// channels in turn; the DONE state then loads the output register once it is free, and IDLE
// takes the next pair. No new pair is taken before the last one reaches the output register.
// A finished result waits in the output register while the next pair is taken.
// Reset (synchronous, rst_n low) clears envelopes, control and registers to defaults.
`timescale 1ns / 1ps

module transient_shaper_stereo_top
  import tss_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // in_tdata fields from bit 0: left_sample, right_sample
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           in_tdata,
  // out_tdata fields from bit 0: left_out, right_out
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((2*(SAMPLE_BITS+2)+7)/8)*8-1:0]       out_tdata,
  input  logic                                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                         cfg_index,
  input  logic [CFG_DATA_W-1:0]                        cfg_data
);

  localparam int WET_W       = SAMPLE_BITS + 2;
  localparam int OUT_TDATA_W = ((2*WET_W+7)/8)*8;
  localparam int OPA_W       = SAMPLE_BITS + 4;
  localparam int PROD_W      = OPA_W + GAIN_W;
  localparam int ACC_W       = PROD_W + 1;

  // Smoothing coefficients in Q0.COEF_BITS, rounded to nearest, and complements.
  localparam logic [COEF_BITS-1:0] C85  =
    COEF_BITS'(((64'd85 << COEF_BITS) + 64'd50) / 64'd100);
  localparam logic [COEF_BITS-1:0] C95  =
    COEF_BITS'(((64'd95 << COEF_BITS) + 64'd50) / 64'd100);
  localparam logic [COEF_BITS-1:0] C995 =
    COEF_BITS'(((64'd995 << COEF_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_BITS-1:0] C85C  = COEF_BITS'((64'd1 << COEF_BITS) - 64'(C85));
  localparam logic [COEF_BITS-1:0] C95C  = COEF_BITS'((64'd1 << COEF_BITS) - 64'(C95));
  localparam logic [COEF_BITS-1:0] C995C = COEF_BITS'((64'd1 << COEF_BITS) - 64'(C995));

  localparam logic [SAMPLE_BITS-1:0]    ENV_MAX     = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic signed [ACC_W-1:0]   WET_LIM     = ACC_W'(1) << SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0]   GAIN_ONE_W  = ACC_W'(GAIN_ONE);
  localparam logic signed [ACC_W-1:0]   FLOOR_W     = ACC_W'(GAIN_FLOOR);
  localparam logic signed [GAIN_W-1:0]  FLOOR_G     = GAIN_W'(GAIN_FLOOR);

  // Sequencer registers.
  fsm_t  state_r, state_nxt;
  step_t step_r, step_nxt;
  logic  ch_r, ch_nxt;
  logic  out_free;
  logic  load_out;

  // Configuration registers, stored as written.
  logic [AMT_W-1:0] reg_att_r;
  logic [AMT_W-1:0] reg_sus_r;
  logic [CTL_W-1:0] reg_sens_r;
  logic [CTL_W-1:0] reg_mix_r;

  // Sample and envelope state.
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;
  logic [SAMPLE_BITS-1:0]        abs_l_r, abs_r_r;
  logic [SAMPLE_BITS-1:0]        fast_l_r, slow_l_r, fast_r_r, slow_r_r;
  logic                          fast_up_r, slow_up_r;
  logic [SAMPLE_BITS-1:0]        diff_r;

  // Datapath registers.
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [GAIN_W-1:0] ga_r, gs_r;
  logic signed [OPA_W-1:0]  t_r;
  logic signed [WET_W-1:0]  wet_r;
  logic signed [WET_W-1:0]  res_l_r, res_r_r;
  logic signed [WET_W-1:0]  out_left_r, out_right_r;
  logic                     out_tvalid_r;

  // Combinational datapath signals.
  logic signed [SAMPLE_BITS-1:0] in_left, in_right, s_cur;
  logic [SAMPLE_BITS-1:0]        in_abs_l, in_abs_r, a_cur, fast_cur, slow_cur, env_rnd;
  logic signed [AMT_W-1:0]       att_c, sus_c, reg_att_s, reg_sus_s;
  logic [CTL_W-1:0]              sens_c, mix_c, dry_w;
  logic [SENSE_W-1:0]            sense;
  logic signed [OPA_W-1:0]       op_a;
  logic signed [GAIN_W-1:0]      op_b;
  logic                          mac, hold;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic [RND_SH_W-1:0]           rnd_sh;
  logic signed [ACC_W-1:0]       rnd_half, rnd_sum, rnd_val;
  logic                          gain_neg;
  logic signed [ACC_W-1:0]       gain_sum;
  logic signed [GAIN_W-1:0]      gain_val;
  logic signed [WET_W-1:0]       wet_val;
  logic                          run;

  // Input unpacking and absolute values taken at the transfer.
  assign in_left  = in_tdata[SAMPLE_BITS-1:0];
  assign in_right = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_abs_l = in_left[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-in_left)  : SAMPLE_BITS'(in_left);
  assign in_abs_r = in_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_right) : SAMPLE_BITS'(in_right);

  // Current channel selection.
  assign s_cur    = ch_r ? right_r  : left_r;
  assign a_cur    = ch_r ? abs_r_r  : abs_l_r;
  assign fast_cur = ch_r ? fast_r_r : fast_l_r;
  assign slow_cur = ch_r ? slow_r_r : slow_l_r;

  // Registers saturate to their legal range when used.
  assign reg_att_s = reg_att_r;
  assign reg_sus_s = reg_sus_r;
  assign att_c  = (reg_att_s > AMT_MAX) ? AMT_MAX : ((reg_att_s < AMT_MIN) ? AMT_MIN : reg_att_s);
  assign sus_c  = (reg_sus_s > AMT_MAX) ? AMT_MAX : ((reg_sus_s < AMT_MIN) ? AMT_MIN : reg_sus_s);
  assign sens_c = (reg_sens_r > Q12_ONE) ? Q12_ONE : reg_sens_r;
  assign mix_c  = (reg_mix_r > Q12_ONE) ? Q12_ONE : reg_mix_r;
  assign dry_w  = Q12_ONE - mix_c;
  assign sense  = SENSE_W'({sens_c, 2'b00}) + SENSE_OFS;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_att_r  <= '0;
      reg_sus_r  <= '0;
      reg_sens_r <= SENSE_RST;
      reg_mix_r  <= Q12_ONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ATTACK:  reg_att_r  <= cfg_data[AMT_W-1:0];
        REG_SUSTAIN: reg_sus_r  <= cfg_data[AMT_W-1:0];
        REG_SENSE:   reg_sens_r <= cfg_data[CTL_W-1:0];
        REG_MIX:     reg_mix_r  <= cfg_data[CTL_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_tvalid) state_nxt = FSM_RUN;
      FSM_RUN:  if (step_r == SP_OUT_WB && ch_r) state_nxt = FSM_DONE;
      FSM_DONE: if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Sequencer outputs.
  assign out_free = !out_tvalid_r || out_tready;
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    run       = 1'b0;
    unique case (state_r)
      FSM_IDLE: in_tready = 1'b1;
      FSM_RUN:  run = 1'b1;
      FSM_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // Step and channel counters.
  always_comb begin
    step_nxt = step_r;
    ch_nxt   = ch_r;
    if (in_tvalid && in_tready) begin
      step_nxt = SP_FAST_MUL;
      ch_nxt   = 1'b0;
    end else if (run) begin
      if (step_r == SP_OUT_WB) begin
        step_nxt = SP_FAST_MUL;
        ch_nxt   = 1'b1;
      end else begin
        step_nxt = step_t'(step_r + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      step_r  <= SP_FAST_MUL;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    mac  = 1'b0;
    hold = 1'b0;
    unique case (step_r)
      SP_FAST_MUL: begin
        op_a = OPA_W'(fast_cur);
        op_b = GAIN_W'(C85);
      end
      SP_FAST_MAC: begin
        op_a = OPA_W'(a_cur);
        op_b = GAIN_W'(C85C);
        mac  = 1'b1;
      end
      SP_SLOW_MUL: begin
        op_a = OPA_W'(slow_cur);
        op_b = slow_up_r ? GAIN_W'(C95) : GAIN_W'(C995);
      end
      SP_SLOW_MAC: begin
        op_a = OPA_W'(a_cur);
        op_b = slow_up_r ? GAIN_W'(C95C) : GAIN_W'(C995C);
        mac  = 1'b1;
      end
      SP_ATT_SENSE: begin
        op_a = OPA_W'(sense);
        op_b = GAIN_W'(att_c);
      end
      SP_ATT_GAIN: begin
        op_a = OPA_W'(diff_r);
        op_b = acc_r[GAIN_W-1:0];
      end
      SP_SUS_SENSE: begin
        op_a = OPA_W'(sense);
        op_b = GAIN_W'(sus_c);
      end
      SP_SUS_GAIN: begin
        op_a = OPA_W'(slow_cur);
        op_b = acc_r[GAIN_W-1:0];
      end
      SP_DRY_GAIN: begin
        op_a = OPA_W'(s_cur);
        op_b = ga_r;
      end
      SP_WET_MUL: begin
        op_a = t_r;
        op_b = gs_r;
      end
      SP_DRY_MIX: begin
        op_a = OPA_W'(s_cur);
        op_b = GAIN_W'(dry_w);
      end
      SP_WET_MIX: begin
        op_a = OPA_W'(wet_r);
        op_b = GAIN_W'(mix_c);
        mac  = 1'b1;
      end
      default: hold = 1'b1;
    endcase
  end

  // Shared multiply-accumulate.
  assign prod    = op_a * op_b;
  assign acc_nxt = hold ? acc_r : ((mac ? acc_r : ACC_W'(0)) + ACC_W'(prod));

  // Round half up of the previous pass, shift chosen by the step.
  always_comb begin
    unique case (step_r) inside
      SP_SLOW_MUL, SP_ATT_SENSE:  rnd_sh = RND_SH_W'(COEF_BITS);
      SP_SUS_SENSE, SP_DRY_GAIN:  rnd_sh = RND_SH_W'(SAMPLE_BITS - 1);
      SP_T_WB, SP_DRY_MIX:        rnd_sh = RND_SH_W'(GAIN_BITS);
      SP_OUT_WB:                  rnd_sh = RND_SH_W'(MIX_FRAC);
      default:                    rnd_sh = RND_SH_W'(COEF_BITS);
    endcase
  end
  assign rnd_half = ACC_W'(1) << (rnd_sh - RND_SH_W'(1));
  assign rnd_sum  = acc_r + rnd_half;
  assign rnd_val  = rnd_sum >>> rnd_sh;
  assign env_rnd  = rnd_val[SAMPLE_BITS-1:0];

  // Gain from the rounded term, with the floor for a cut.
  assign gain_neg = (step_r == SP_SUS_SENSE) ? att_c[AMT_W-1] : sus_c[AMT_W-1];
  assign gain_sum = GAIN_ONE_W + rnd_val;
  assign gain_val = (gain_neg && gain_sum < FLOOR_W) ? FLOOR_G : gain_sum[GAIN_W-1:0];

  // Wet sample saturated to plus or minus 2.0.
  assign wet_val = (rnd_val > WET_LIM) ? WET_LIM[WET_W-1:0] :
                   ((rnd_val < -WET_LIM) ? WET_W'(-WET_LIM) : rnd_val[WET_W-1:0]);

  // Input capture and per-step write-back into the datapath registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      left_r  <= in_left;
      right_r <= in_right;
      abs_l_r <= in_abs_l;
      abs_r_r <= in_abs_r;
    end
    if (run) begin
      acc_r <= acc_nxt;
      unique case (step_r)
        SP_FAST_MUL: begin
          fast_up_r <= a_cur > fast_cur;
          slow_up_r <= a_cur > slow_cur;
        end
        SP_ATT_SENSE: diff_r <= (fast_cur > env_rnd) ? (fast_cur - env_rnd) : '0;
        SP_SUS_SENSE: ga_r <= gain_val;
        SP_DRY_GAIN:  gs_r <= gain_val;
        SP_T_WB:      t_r <= rnd_val[OPA_W-1:0];
        SP_DRY_MIX:   wet_r <= wet_val;
        SP_OUT_WB: begin
          if (ch_r) res_r_r <= rnd_val[WET_W-1:0];
          else      res_l_r <= rnd_val[WET_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Envelope state, reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_l_r <= '0;
      slow_l_r <= '0;
      fast_r_r <= '0;
      slow_r_r <= '0;
    end else if (run && step_r == SP_SLOW_MUL) begin
      if (ch_r) fast_r_r <= fast_up_r ? a_cur : env_rnd;
      else      fast_l_r <= fast_up_r ? a_cur : env_rnd;
    end else if (run && step_r == SP_ATT_SENSE) begin
      if (ch_r) slow_r_r <= env_rnd;
      else      slow_l_r <= env_rnd;
    end
  end

  // Output register; it holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_left_r  <= res_l_r;
      out_right_r <= res_r_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_right_r, out_left_r});

  // A transfer starts the left channel at the first pass.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == FSM_RUN && step_r == SP_FAST_MUL && !ch_r))
    else $error("sequence did not start at the first pass after a transfer");

  // Envelopes never exceed full scale.
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fast_l_r <= ENV_MAX && slow_l_r <= ENV_MAX && fast_r_r <= ENV_MAX && slow_r_r <= ENV_MAX))
    else $error("envelope above full scale");

  // Both gains are at or above the floor once they are used.
  a_gain_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_RUN && step_r == SP_WET_MUL) |-> (ga_r >= FLOOR_G && gs_r >= FLOOR_G))
    else $error("gain below floor");

  // The right channel's last pass hands over to the output stage.
  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_RUN && step_r == SP_OUT_WB && ch_r) |=> (state_r == FSM_DONE))
    else $error("sequence did not finish after the right channel");

endmodule
